FILE: design/bds_pkg.sv
package bds_pkg;

    localparam logic [1:0] OP_PRESS   = 2'd0;
    localparam logic [1:0] OP_RELEASE = 2'd1;
    localparam logic [1:0] OP_TICK    = 2'd2;

    localparam logic [3:0] SENS_A1 = 4'b0001;
    localparam logic [3:0] SENS_A2 = 4'b0010;
    localparam logic [3:0] SENS_B1 = 4'b0100;
    localparam logic [3:0] SENS_B2 = 4'b1000;

    localparam logic [2:0] SENS_NONE = 3'd4;
    localparam logic [2:0] SENS_ID_A2 = 3'd1;
    localparam logic [2:0] SENS_ID_B1 = 3'd2;

    localparam logic [1:0] REG_SHORT   = 2'd0;
    localparam logic [1:0] REG_LONG    = 2'd1;
    localparam logic [1:0] REG_CONFIRM = 2'd2;
    localparam logic [1:0] REG_PULSE   = 2'd3;

    localparam logic [15:0] SHORT_RST   = 16'd400;
    localparam logic [15:0] LONG_RST    = 16'd500;
    localparam logic [15:0] CONFIRM_RST = 16'd100;
    localparam logic [15:0] PULSE_RST   = 16'd14;

endpackage

FILE: design/barrier_direction_sequencer.sv
// Barrier direction sequencer. Takes sensor press, release and tick
// transactions and returns one result transaction per input: the direction
// state, alarm level, open/close drive levels, barrier open status and a
// moving flag, all as they stand after that input. One input is accepted per
// clock; the whole step (timers, direction state machine, pulse drive) is
// done in the cycle of acceptance and the result is held until taken, with
// the next input accepted on the same edge the result is taken. Registers
// 0..3 (short timeout, long timeout, confirm timeout, pulse length) must be
// written through the configuration port while the block is idle (unenforced).
module barrier_direction_sequencer
    import bds_pkg::*;
#(
    parameter int TIMER_BITS = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_index,
    input  logic [15:0] i_cfg_data,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [1:0]  i_operation,
    input  logic [1:0]  i_sensor_id,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [2:0]  o_fsm_state,
    output logic        o_alarm_on,
    output logic        o_open_drive,
    output logic        o_close_drive,
    output logic        o_barrier_is_open,
    output logic        o_barrier_moving
);

    typedef enum logic [2:0] {
        ST_IDLE    = 3'd0,
        ST_PROC_AB = 3'd1,
        ST_PROC_BA = 3'd2,
        ST_OPT_AB  = 3'd3,
        ST_OPT_BA  = 3'd4,
        ST_FORCED  = 3'd5,
        ST_CONFIRM = 3'd6
    } t_mode;

    typedef logic [TIMER_BITS-1:0] t_timer;

    function automatic t_timer timer_fit(input logic [15:0] v);
        logic [TIMER_BITS+15:0] wide;
        wide = {{TIMER_BITS{1'b0}}, v};
        return wide[TIMER_BITS-1:0];
    endfunction

    localparam t_timer TIMER_ONE = t_timer'(1);

    logic [15:0] r_short, r_long, r_confirm_to, r_pulse_len;
    t_mode       r_mode, n_mode;
    logic [3:0]  r_flags, n_flags;
    logic [2:0]  r_recent, n_recent;
    logic [2:0]  r_earlier, n_earlier;
    t_timer      r_guard_cnt, n_guard_cnt;
    logic        r_guard_run, n_guard_run;
    t_timer      r_conf_cnt, n_conf_cnt;
    logic        r_conf_run, n_conf_run;
    logic        r_open_req, n_open_req;
    logic        r_close_req, n_close_req;
    logic [15:0] r_pulse_cnt, n_pulse_cnt;
    logic        r_pulse_open, n_pulse_open;
    logic        r_open_stat, n_open_stat;
    logic        r_alarm, n_alarm;
    logic        r_out_valid, n_out_valid;

    logic        in_acc;
    logic [3:0]  f;
    logic [15:0] len;
    logic        moving;

    assign o_in_ready = !r_out_valid || i_out_ready;
    assign in_acc     = i_in_valid && o_in_ready;
    assign f          = r_flags;
    assign len        = (r_pulse_len == 16'd0) ? 16'd1 : r_pulse_len;

    always_comb begin
        n_mode       = r_mode;
        n_flags      = r_flags;
        n_recent     = r_recent;
        n_earlier    = r_earlier;
        n_guard_cnt  = r_guard_cnt;
        n_guard_run  = r_guard_run;
        n_conf_cnt   = r_conf_cnt;
        n_conf_run   = r_conf_run;
        n_open_req   = r_open_req;
        n_close_req  = r_close_req;
        n_pulse_cnt  = r_pulse_cnt;
        n_pulse_open = r_pulse_open;
        n_open_stat  = r_open_stat;
        n_alarm      = r_alarm;
        n_out_valid  = r_out_valid;
        if (i_out_ready) begin
            n_out_valid = 1'b0;
        end
        if (in_acc) begin
            n_out_valid = 1'b1;
            case (i_operation)
                OP_PRESS: begin
                    n_flags   = r_flags | (4'b0001 << i_sensor_id);
                    n_earlier = r_recent;
                    n_recent  = {1'b0, i_sensor_id};
                end
                OP_TICK: begin
                    // timers
                    if (r_guard_run) begin
                        if (r_guard_cnt <= TIMER_ONE) begin
                            n_guard_cnt = '0;
                            n_guard_run = 1'b0;
                            n_alarm     = 1'b0;
                            n_open_req  = 1'b1;
                            n_mode      = ST_IDLE;
                        end else begin
                            n_guard_cnt = r_guard_cnt - TIMER_ONE;
                        end
                    end
                    if (r_conf_run) begin
                        if (r_conf_cnt <= TIMER_ONE) begin
                            n_conf_cnt = '0;
                            n_conf_run = 1'b0;
                            if (n_mode == ST_CONFIRM) begin
                                n_alarm    = 1'b0;
                                n_open_req = 1'b1;
                                n_mode     = ST_IDLE;
                            end
                        end else begin
                            n_conf_cnt = r_conf_cnt - TIMER_ONE;
                        end
                    end
                    // direction state machine
                    case (n_mode)
                        ST_IDLE: begin
                            if ((f & SENS_A1) != 4'd0) begin
                                n_mode = ST_PROC_AB; n_alarm = 1'b1;
                                n_flags = n_flags & ~SENS_A1;
                                n_guard_cnt = timer_fit(r_short); n_guard_run = 1'b1;
                            end else if ((f & SENS_B2) != 4'd0) begin
                                n_mode = ST_PROC_BA; n_close_req = 1'b1; n_alarm = 1'b1;
                                n_flags = n_flags & ~SENS_B2;
                                n_guard_cnt = timer_fit(r_short); n_guard_run = 1'b1;
                            end else if ((f & (SENS_A2 | SENS_B1)) != 4'd0) begin
                                n_mode = ST_FORCED; n_close_req = 1'b1; n_alarm = 1'b1;
                                n_flags = n_flags & ~(SENS_A2 | SENS_B1);
                                n_guard_cnt = timer_fit(r_long); n_guard_run = 1'b1;
                            end
                        end
                        ST_PROC_AB: begin
                            if ((f & SENS_A2) != 4'd0) begin
                                n_mode = ST_OPT_AB; n_close_req = 1'b1;
                                n_flags = n_flags & ~SENS_A2;
                                n_guard_cnt = timer_fit(r_long); n_guard_run = 1'b1;
                            end else if ((f & SENS_A1) != 4'd0) begin
                                n_flags = n_flags & ~SENS_A1;
                                n_guard_cnt = timer_fit(r_short); n_guard_run = 1'b1;
                            end else if ((f & (SENS_B1 | SENS_B2)) != 4'd0) begin
                                n_mode = ST_FORCED; n_close_req = 1'b1; n_alarm = 1'b1;
                                n_flags = n_flags & ~(SENS_B1 | SENS_B2);
                                n_guard_cnt = timer_fit(r_long); n_guard_run = 1'b1;
                            end
                        end
                        ST_PROC_BA: begin
                            if ((f & SENS_B1) != 4'd0) begin
                                n_mode = ST_OPT_BA; n_close_req = 1'b1;
                                n_flags = n_flags & ~SENS_B1;
                                n_guard_cnt = timer_fit(r_long); n_guard_run = 1'b1;
                            end else if ((f & SENS_B2) != 4'd0) begin
                                n_flags = n_flags & ~SENS_B2;
                                n_guard_cnt = timer_fit(r_short); n_guard_run = 1'b1;
                            end else if ((f & (SENS_A1 | SENS_A2)) != 4'd0) begin
                                n_mode = ST_FORCED; n_close_req = 1'b1; n_alarm = 1'b1;
                                n_flags = n_flags & ~(SENS_A1 | SENS_A2);
                                n_guard_cnt = timer_fit(r_long); n_guard_run = 1'b1;
                            end
                        end
                        ST_OPT_AB: begin
                            if ((f & SENS_B2) != 4'd0) begin
                                n_flags = n_flags & ~SENS_B2;
                                n_mode = ST_CONFIRM; n_alarm = 1'b0; n_guard_run = 1'b0;
                                n_conf_cnt = timer_fit(r_confirm_to); n_conf_run = 1'b1;
                            end else if ((f & SENS_B1) != 4'd0) begin
                                n_flags = n_flags & ~SENS_B1;
                                n_guard_cnt = timer_fit(r_short); n_guard_run = 1'b1;
                            end else if ((f & (SENS_A1 | SENS_A2)) != 4'd0) begin
                                n_mode = ST_FORCED; n_close_req = 1'b1; n_alarm = 1'b1;
                                n_flags = n_flags & ~(SENS_A1 | SENS_A2);
                                n_guard_cnt = timer_fit(r_short); n_guard_run = 1'b1;
                            end
                        end
                        ST_OPT_BA: begin
                            if ((f & SENS_A1) != 4'd0) begin
                                n_flags = n_flags & ~SENS_A1;
                                n_mode = ST_CONFIRM; n_alarm = 1'b0; n_guard_run = 1'b0;
                                n_conf_cnt = timer_fit(r_confirm_to); n_conf_run = 1'b1;
                            end else if ((f & SENS_A2) != 4'd0) begin
                                n_flags = n_flags & ~SENS_A2;
                                n_guard_cnt = timer_fit(r_short); n_guard_run = 1'b1;
                            end else if ((f & (SENS_B1 | SENS_B2)) != 4'd0) begin
                                n_mode = ST_FORCED; n_close_req = 1'b1; n_alarm = 1'b1;
                                n_flags = n_flags & ~(SENS_B1 | SENS_B2);
                                n_guard_cnt = timer_fit(r_long); n_guard_run = 1'b1;
                            end
                        end
                        ST_FORCED: begin
                            if ((f & (SENS_A1 | SENS_B2)) != 4'd0) begin
                                if (r_earlier == SENS_ID_A2 || r_earlier == SENS_ID_B1) begin
                                    n_mode = ST_CONFIRM; n_alarm = 1'b0; n_guard_run = 1'b0;
                                    n_conf_cnt = timer_fit(r_confirm_to); n_conf_run = 1'b1;
                                end else begin
                                    n_alarm = 1'b1; n_close_req = 1'b1;
                                    n_guard_cnt = timer_fit(r_short); n_guard_run = 1'b1;
                                end
                                n_flags = n_flags & ~(SENS_A1 | SENS_B2);
                            end else if ((f & (SENS_A2 | SENS_B1)) != 4'd0) begin
                                n_alarm = 1'b1; n_close_req = 1'b1;
                                n_flags = n_flags & ~(SENS_A2 | SENS_B1);
                                n_guard_cnt = timer_fit(r_long); n_guard_run = 1'b1;
                            end
                        end
                        ST_CONFIRM: begin
                            if ((f & (SENS_A1 | SENS_A2)) != 4'd0) begin
                                n_mode = ST_OPT_AB; n_alarm = 1'b1; n_close_req = 1'b1;
                                n_flags = n_flags & ~(SENS_A1 | SENS_A2);
                                n_guard_cnt = timer_fit(r_short); n_guard_run = 1'b1;
                            end else if ((f & (SENS_B1 | SENS_B2)) != 4'd0) begin
                                n_mode = ST_OPT_BA; n_alarm = 1'b1; n_close_req = 1'b1;
                                n_flags = n_flags & ~(SENS_B1 | SENS_B2);
                                n_guard_cnt = timer_fit(r_short); n_guard_run = 1'b1;
                            end
                        end
                        default: begin
                            n_mode = ST_IDLE;
                        end
                    endcase
                    // pulse drive: close wins over open
                    if (r_pulse_cnt != 16'd0) begin
                        n_pulse_cnt = r_pulse_cnt - 16'd1;
                        if (n_pulse_cnt == 16'd0) begin
                            n_open_stat = r_pulse_open;
                            if (r_pulse_open) begin
                                n_alarm = 1'b0;
                            end
                        end
                    end
                    if (n_pulse_cnt == 16'd0) begin
                        if (n_close_req) begin
                            n_close_req  = 1'b0;
                            n_pulse_open = 1'b0;
                            n_pulse_cnt  = len;
                        end else if (n_open_req) begin
                            n_open_req   = 1'b0;
                            n_pulse_open = 1'b1;
                            n_pulse_cnt  = len;
                        end
                    end
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_short      <= SHORT_RST;
            r_long       <= LONG_RST;
            r_confirm_to <= CONFIRM_RST;
            r_pulse_len  <= PULSE_RST;
            r_mode       <= ST_IDLE;
            r_flags      <= 4'd0;
            r_recent     <= SENS_NONE;
            r_earlier    <= SENS_NONE;
            r_guard_cnt  <= timer_fit(SHORT_RST);
            r_guard_run  <= 1'b1;
            r_conf_cnt   <= '0;
            r_conf_run   <= 1'b0;
            r_open_req   <= 1'b0;
            r_close_req  <= 1'b0;
            r_pulse_cnt  <= 16'd0;
            r_pulse_open <= 1'b0;
            r_open_stat  <= 1'b1;
            r_alarm      <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    REG_SHORT:   r_short      <= i_cfg_data;
                    REG_LONG:    r_long       <= i_cfg_data;
                    REG_CONFIRM: r_confirm_to <= i_cfg_data;
                    REG_PULSE:   r_pulse_len  <= i_cfg_data;
                    default: begin
                    end
                endcase
            end
            r_mode       <= n_mode;
            r_flags      <= n_flags;
            r_recent     <= n_recent;
            r_earlier    <= n_earlier;
            r_guard_cnt  <= n_guard_cnt;
            r_guard_run  <= n_guard_run;
            r_conf_cnt   <= n_conf_cnt;
            r_conf_run   <= n_conf_run;
            r_open_req   <= n_open_req;
            r_close_req  <= n_close_req;
            r_pulse_cnt  <= n_pulse_cnt;
            r_pulse_open <= n_pulse_open;
            r_open_stat  <= n_open_stat;
            r_alarm      <= n_alarm;
            r_out_valid  <= n_out_valid;
        end
    end

    assign moving            = (r_pulse_cnt != 16'd0);
    assign o_out_valid       = r_out_valid;
    assign o_fsm_state       = r_mode;
    assign o_alarm_on        = r_alarm;
    assign o_open_drive      = moving && r_pulse_open;
    assign o_close_drive     = moving && !r_pulse_open;
    assign o_barrier_is_open = r_open_stat;
    assign o_barrier_moving  = moving;

endmodule
